// ===== rtl/core/sym_herm_rank1_update_top_defines.svh =====
// ----------------------------------------------------------------------------
// sym_herm_rank1_update_top_defines
// assertion macros for the rank-1 update block
// ----------------------------------------------------------------------------
`ifndef SYM_HERM_RANK1_UPDATE_TOP_DEFINES_SVH
`define SYM_HERM_RANK1_UPDATE_TOP_DEFINES_SVH
// concurrent implication checked on every rising clock edge outside reset
`define SHR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define SHR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/shr_pkg.sv =====
// ----------------------------------------------------------------------------
// shr_pkg
// types and constants for the rank-1 update top, controller and datapath
// ----------------------------------------------------------------------------
package shr_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_PUSH  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] CFG_ALPHA_RE = 3'd0;
  localparam logic [2:0] CFG_ALPHA_IM = 3'd1;
  localparam logic [2:0] CFG_HERM     = 3'd2;
  localparam logic [2:0] CFG_CONJ     = 3'd3;
  localparam logic [2:0] CFG_ACC      = 3'd4;
  localparam logic [2:0] CFG_SIZE     = 3'd5;

  // commands from controller to datapath
  typedef struct packed {
    logic load;     // latch input item
    logic wr_entry; // store write item
    logic x_wr;     // store x element
    logic rd_issue; // issue matrix and x read for current column or read item
    logic mul1;     // x operand stage
    logic mul2;     // x product stage
    logic commit;   // add, saturate, write back, load output
    logic rd_out;   // load output from read data (read item)
    logic is_last;
  } shr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       idx_ok;
  } shr_sts_t;

endpackage

// ===== rtl/core/sym_herm_rank1_update_top.sv =====
// ----------------------------------------------------------------------------
// sym_herm_rank1_update_top
// rank-1 update of a complex symmetric or Hermitian matrix, lower triangle
// ----------------------------------------------------------------------------
// One item is handled at a time. A write stores its entry after decode; a
// read issues the memory read and then loads the result register, and no new
// item is taken until that result has been taken by the receiver.
// A push of row i gives i+1 results, one entry at a time, each passing the
// memory read, the x product, the alpha product and the write back, with the
// next item taken once the last result of the push has been taken.
// A stalled result holds the column loop. The matrix store holds no reset;
// read only entries written before.
module sym_herm_rank1_update_top import shr_pkg::*; #(
  parameter int MAX_N           = 16,
  parameter int ENTRY_FRAC_BITS = 23
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: x_re, x_im, row_index, col_index, entry_re, entry_im
  input  logic [103:0] s_axis_tdata,
  // tuser: op
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: out_re, out_im, out_row, out_col, saturated
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  `include "sym_herm_rank1_update_top_defines.svh"

  localparam int IW = $clog2(MAX_N);

  // configuration registers
  logic signed [15:0] alpha_re_q, alpha_im_q;
  logic herm_q, conj_q, acc_q;
  logic [4:0] size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_re_q <= 16'sd2048; alpha_im_q <= '0; herm_q <= 1'b0;
      conj_q <= 1'b0; acc_q <= 1'b1; size_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA_RE: alpha_re_q <= cfg_data_i;
        CFG_ALPHA_IM: alpha_im_q <= cfg_data_i;
        CFG_HERM:     herm_q <= cfg_data_i[0];
        CFG_CONJ:     conj_q <= cfg_data_i[0];
        CFG_ACC:      acc_q <= cfg_data_i[0];
        CFG_SIZE:     size_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  shr_cmd_t cmd;
  shr_sts_t sts;
  logic [IW-1:0] row, col;
  logic [73:0] res;

  shr_ctrl #(.MaxN(MAX_N)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .size_i(size_q), .sts_i(sts), .cmd_o(cmd), .row_o(row), .col_o(col)
  );

  shr_datapath #(.MaxN(MAX_N), .EntryFracBits(ENTRY_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .row_i(row), .col_i(col),
    .in_op_i(s_axis_tuser),
    .in_x_re_i(s_axis_tdata[15:0]), .in_x_im_i(s_axis_tdata[31:16]),
    .in_row_i(s_axis_tdata[35:32]), .in_col_i(s_axis_tdata[39:36]),
    .in_e_re_i(s_axis_tdata[71:40]), .in_e_im_i(s_axis_tdata[103:72]),
    .alpha_re_i(alpha_re_q), .alpha_im_i(alpha_im_q),
    .herm_i(herm_q), .conj_i(conj_q), .acc_i(acc_q), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res[1], res[5:2], res[9:6], res[41:10], res[73:42]};
  assign m_axis_tlast = res[0];

  // checks
  `SHR_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid,
    "input accepted while result pending")
  `SHR_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `SHR_ASSERT_IMP(a_onecmd, clk_i, rst_ni, 1'b1,
    $onehot0({cmd.wr_entry, cmd.commit, cmd.rd_out}), "conflicting commands")

endmodule

// ===== rtl/core/shr_datapath.sv =====
// ----------------------------------------------------------------------------
// shr_datapath
// matrix and x memories, complex multiply-accumulate with saturation
// ----------------------------------------------------------------------------
module shr_datapath import shr_pkg::*; #(
  parameter int MaxN          = 16,
  parameter int EntryFracBits = 23
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  shr_cmd_t                 cmd_i,
  output shr_sts_t                 sts_o,
  input  logic [$clog2(MaxN)-1:0]  row_i,   // push row from controller
  input  logic [$clog2(MaxN)-1:0]  col_i,   // push column from controller
  input  logic [1:0]               in_op_i,
  input  logic signed [15:0]       in_x_re_i,
  input  logic signed [15:0]       in_x_im_i,
  input  logic [3:0]               in_row_i,
  input  logic [3:0]               in_col_i,
  input  logic signed [31:0]       in_e_re_i,
  input  logic signed [31:0]       in_e_im_i,
  input  logic signed [15:0]       alpha_re_i,
  input  logic signed [15:0]       alpha_im_i,
  input  logic                     herm_i,
  input  logic                     conj_i,
  input  logic                     acc_i,
  output logic [73:0]              res_o     // re, im, row, col, sat, last
);

  localparam int IW    = (MaxN > 1) ? $clog2(MaxN) : 1;
  localparam int Depth = MaxN * (MaxN + 1) / 2;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Shift = 37 - EntryFracBits;

  logic [63:0] mat_mem [Depth];
  logic [31:0] x_mem [MaxN];
  logic [63:0] mrd_q;
  logic [31:0] xrd_q;

  logic [1:0]        op_q;
  logic signed [15:0] xi_re_q, xi_im_q;
  logic [3:0]        r_q, c_q;
  logic signed [31:0] e_re_q, e_im_q;

  // latch the incoming item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= in_op_i; xi_re_q <= in_x_re_i; xi_im_q <= in_x_im_i;
      r_q <= in_row_i; c_q <= in_col_i; e_re_q <= in_e_re_i; e_im_q <= in_e_im_i;
    end
  end

  // index checks and mirroring
  logic       idx_ok, upper;
  logic [3:0] lr, lc;
  always_comb begin
    idx_ok = (32'(r_q) < MaxN) && (32'(c_q) < MaxN);
    upper  = c_q > r_q;
    lr     = upper ? c_q : r_q;
    lc     = upper ? r_q : c_q;
  end
  assign sts_o.op     = op_q;
  assign sts_o.idx_ok = idx_ok;

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    neg_sat = (v == 32'h8000_0000) ? 32'h7fff_ffff : 32'(-v);
  endfunction

  // triangle address
  logic [AW-1:0] item_addr, push_addr, rd_addr;
  always_comb begin
    item_addr = AW'((32'(lr) * (32'(lr) + 1)) / 2 + 32'(lc));
    push_addr = AW'((32'(row_i) * (32'(row_i) + 1)) / 2 + 32'(col_i));
    rd_addr   = (op_q == OP_PUSH) ? push_addr : item_addr;
  end

  // pipeline of one update entry
  logic signed [16:0] ar_q, ai_q, br_q, bi_q;
  logic signed [34:0] pr_q, pi_q;
  logic signed [53:0] tr_q, ti_q;
  logic signed [63:0] wr_data;
  logic               pipe_col_diag;
  logic [31:0]        new_re, new_im;
  logic               clip_r, clip_i, azero;

  assign azero = (alpha_re_i == 16'sd0) && (herm_i || alpha_im_i == 16'sd0);

  // memories, x of the current row bypassed on the diagonal
  logic [31:0] x_wdata;
  assign x_wdata = {xi_im_q, xi_re_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.x_wr) x_mem[row_i] <= x_wdata;
    if (cmd_i.rd_issue) begin
      mrd_q <= mat_mem[rd_addr];
      xrd_q <= (col_i == row_i) ? x_wdata : x_mem[col_i];
    end
    if (cmd_i.wr_entry)
      mat_mem[item_addr] <= {(upper && herm_i) ? neg_sat(e_im_q) : e_im_q, e_re_q};
    else if (cmd_i.commit && !azero)
      mat_mem[push_addr] <= wr_data;
  end

  // x products: a = x[row] (conj if conj), b = x[col] (conj if conj != herm)
  logic signed [15:0] yre, yim;
  assign yre = xrd_q[15:0];
  assign yim = xrd_q[31:16];
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      ar_q <= 17'(xi_re_q);
      ai_q <= conj_i ? -17'(xi_im_q) : 17'(xi_im_q);
      br_q <= 17'(yre);
      bi_q <= (herm_i == conj_i) ? 17'(yim) : -17'(yim);
    end
  end

  logic signed [34:0] pr_d, pi_d;
  always_comb begin
    pr_d = 35'(ar_q * br_q) - 35'(ai_q * bi_q);
    pi_d = 35'(ar_q * bi_q) + 35'(ai_q * br_q);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin pr_q <= pr_d; pi_q <= pi_d; end
  end

  // alpha products, registered in the cycle after the x products
  logic signed [16:0] alr, ali;
  assign alr = 17'(alpha_re_i);
  assign ali = herm_i ? 17'sd0 : 17'(alpha_im_i);
  logic signed [53:0] tr_d, ti_d;
  always_comb begin
    tr_d = 54'(alr * pr_q) - 54'(ali * pi_q);
    ti_d = 54'(alr * pi_q) + 54'(ali * pr_q);
  end
  logic signed [31:0] old_re_q, old_im_q;
  always_ff @(posedge clk_i) begin
    tr_q <= tr_d; ti_q <= ti_d;
    old_re_q <= mrd_q[31:0]; old_im_q <= mrd_q[63:32];
  end

  // round, accumulate, saturate; diagonal imaginary part cleared in hermitian mode
  logic signed [55:0] rr, ri, sr, si;
  always_comb begin
    rr = (56'(tr_q) + (56'sd1 <<< (Shift - 1))) >>> Shift;
    ri = (56'(ti_q) + (56'sd1 <<< (Shift - 1))) >>> Shift;
    sr = rr + (acc_i ? 56'(old_re_q) : 56'sd0);
    si = ri + (acc_i ? 56'(old_im_q) : 56'sd0);
    clip_r = (sr > 56'sd2147483647) || (sr < -56'sd2147483648);
    clip_i = (si > 56'sd2147483647) || (si < -56'sd2147483648);
    new_re = clip_r ? (sr[55] ? 32'h8000_0000 : 32'h7fff_ffff) : sr[31:0];
    new_im = clip_i ? (si[55] ? 32'h8000_0000 : 32'h7fff_ffff) : si[31:0];
    pipe_col_diag = (col_i == row_i) && herm_i;
    if (pipe_col_diag) begin new_im = 32'd0; clip_i = 1'b0; end
    wr_data = {new_im, new_re};
  end

  // read item data, zero for an out-of-range index, mirrored entry conjugated in hermitian mode
  logic [31:0] o_re, o_im;
  always_comb begin
    o_re = idx_ok ? mrd_q[31:0] : 32'd0;
    o_im = idx_ok ? ((upper && herm_i) ? neg_sat(mrd_q[63:32]) : mrd_q[63:32]) : 32'd0;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (azero) res_o <= {old_re_q, old_im_q, 4'(row_i), 4'(col_i), 1'b0, cmd_i.is_last};
      else res_o <= {new_re, new_im, 4'(row_i), 4'(col_i), clip_r || clip_i, cmd_i.is_last};
    end else if (cmd_i.rd_out) begin
      res_o <= {o_re, o_im, r_q, c_q, 1'b0, 1'b1};
    end
  end

  logic unused;
  assign unused = rst_ni ^ (IW != 0);

endmodule

// ===== rtl/core/shr_ctrl.sv =====
// ----------------------------------------------------------------------------
// shr_ctrl
// sequencer for item handling, push column loop and output handshake
// ----------------------------------------------------------------------------
module shr_ctrl import shr_pkg::*; #(
  parameter int MaxN = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  input  logic [4:0]              size_i,
  input  shr_sts_t                sts_i,
  output shr_cmd_t                cmd_o,
  output logic [$clog2(MaxN)-1:0] row_o,
  output logic [$clog2(MaxN)-1:0] col_o
);

  localparam int IW = $clog2(MaxN);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_RD   = 8'b00000100,
    S_M1   = 8'b00001000,
    S_M2   = 8'b00010000,
    S_M3   = 8'b00100000,
    S_CMT  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_e;

  state_e         state_q, state_d;
  logic [IW-1:0]  prow_q, prow_d, row_q, row_d, col_q, col_d;
  logic           ov_q, ov_d;
  logic [6:0]     n_eff;

  always_comb begin
    n_eff = 7'(size_i);
    if (n_eff == 7'd0) n_eff = 7'd1;
    if (32'(n_eff) > MaxN) n_eff = 7'(MaxN);
  end

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign row_o = row_q;
  assign col_o = col_q;

  // next state and commands
  always_comb begin
    state_d = state_q; prow_d = prow_q; row_d = row_q; col_d = col_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.is_last = (col_q == row_q);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1; state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.op)
          OP_WRITE: begin
            cmd_o.wr_entry = sts_i.idx_ok; state_d = S_IDLE;
          end
          OP_READ: begin
            cmd_o.rd_issue = 1'b1; state_d = S_OUT;
          end
          OP_PUSH: begin
            row_d = (32'(prow_q) >= 32'(n_eff)) ? '0 : prow_q;
            col_d = '0; state_d = S_RD;
          end
          default: state_d = S_IDLE;
        endcase
      end
      // result register free, or emptied at this edge
      S_RD: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.x_wr = (col_q == '0); cmd_o.rd_issue = 1'b1; state_d = S_M1;
        end
      end
      S_M1: begin cmd_o.mul1 = 1'b1; state_d = S_M2; end
      S_M2: begin cmd_o.mul2 = 1'b1; state_d = S_M3; end
      // alpha product registers
      S_M3: begin state_d = S_CMT; end
      S_CMT: begin
        cmd_o.commit = 1'b1; ov_d = 1'b1;
        if (col_q == row_q) begin
          prow_d = (32'(row_q) + 1 >= 32'(n_eff)) ? '0 : IW'(32'(row_q) + 1);
          state_d = S_IDLE;
        end else begin
          col_d = col_q + 1'b1; state_d = S_RD;
        end
      end
      S_OUT: begin cmd_o.rd_out = 1'b1; ov_d = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; prow_q <= '0; row_q <= '0; col_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d; prow_q <= prow_d; row_q <= row_d; col_q <= col_d;
      ov_q <= ov_d;
    end
  end

endmodule
